// ===== rtl/move_to_front_codec_core_assert.svh =====
// Assertion macros for the move-to-front codec.
`ifndef MOVE_TO_FRONT_CODEC_CORE_ASSERT_SVH
`define MOVE_TO_FRONT_CODEC_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock, ignored while reset is asserted.
`define MTFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on the rising clock, also during reset.
`define MTFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define MTFC_ASSERT(lbl, prop, msg)

`define MTFC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/mtf_codec_pkg.sv =====
`default_nettype none

package mtf_codec_pkg;

  localparam int unsigned CODE_W = 8;

  localparam logic [CODE_W-1:0] SYM_DOLLAR = 8'h24;
  localparam logic [CODE_W-1:0] SYM_A      = 8'h61;

  // Mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic              load;
    logic              restart;
    logic              decode;
    logic [CODE_W-1:0] code;
  } cell_ctrl_t;

  // One result beat
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bad;
  } result_t;

  // Initial symbol of list position idx: '$' first, then 'a' upward modulo 256
  function automatic logic [CODE_W-1:0] init_sym(input int unsigned idx);
    logic [CODE_W-1:0] sym;
    if (idx == 0) begin
      sym = SYM_DOLLAR;
    end else begin
      sym = CODE_W'(int'(SYM_A) + int'(idx) - 1);
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtf_codec_cell.sv =====
`default_nettype none

module mtf_codec_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mtf_codec_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic                                found_i,
  input  wire logic [mtf_codec_pkg::CODE_W-1:0]    left_sym_i,
  input  wire logic                                before_i,
  output logic [mtf_codec_pkg::CODE_W-1:0]         cur_o,
  output logic                                     before_o,
  output logic                                     first_o
);

  localparam logic [mtf_codec_pkg::CODE_W-1:0] INIT = mtf_codec_pkg::init_sym(INDEX);

  logic [mtf_codec_pkg::CODE_W-1:0] sym_q, sym_d;
  logic                             match;

  // Apply restart before the compare
  assign cur_o = ctrl_i.restart ? INIT : sym_q;

  // Match on position in decode mode, on content in encode mode
  always_comb begin
    if (ctrl_i.decode) begin
      match = (ctrl_i.code == mtf_codec_pkg::CODE_W'(INDEX));
    end else begin
      match = (cur_o == ctrl_i.code);
    end
  end

  // Pass the earlier-hit flag down the row
  assign before_o = before_i | match;
  assign first_o  = match & ~before_i;

  // Shift from the neighbor up to the hit position, else keep
  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.load) begin
      if (found_i && !before_i) begin
        sym_d = left_sym_i;
      end else begin
        sym_d = cur_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= INIT;
    end else begin
      sym_q <= sym_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtf_codec_out.sv =====
`default_nettype none

module mtf_codec_out (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire mtf_codec_pkg::result_t  result_i,
  input  wire logic                    stall_i,
  output logic                         take_ok_o,
  output logic                         valid_o,
  output mtf_codec_pkg::result_t       result_o
);

  logic                   valid_q, valid_d;
  mtf_codec_pkg::result_t result_q, result_d;

  // Room for a new beat when empty or when the held beat leaves now
  assign take_ok_o = !valid_q || !stall_i;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (load_i) begin
      valid_d  = 1'b1;
      result_d = result_i;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/move_to_front_codec_core.sv =====
// Move-to-front coder over '$' followed by 'a'..'z' (ALPHABET_SIZE entries).
// Input channel: in_valid_i / in_stall_o carry code_in_i and restart_i. In
// encode mode code_in_i is a symbol byte, in decode mode a list index.
// Output channel: out_valid_o / out_stall_i carry code_out_o and bad_item_o,
// exactly one result beat per input beat, in order.
// Config: cfg_valid_i / cfg_ready_o write cfg_data_i into the mode register
// (0 encode, 1 decode); write it only while the block is idle.
// Throughput: one item per cycle unless output stalls. The list sits in a row
// of cells, one symbol each; compare, first-hit chain and shift toward the hit
// all finish in the accepting cycle. Result valid the cycle after acceptance.
// A restart flag reloads the initial order before its item is processed.
// Bad symbols or indices give code_out 0, bad_item 1 and leave the list alone.
// Reset loads the initial order, clears mode to encode and empties the output.
// While the receiver stalls a full output register, in_stall_o is raised and
// the held result stays unchanged.

`default_nettype none

`include "move_to_front_codec_core_assert.svh"

module move_to_front_codec_core #(
  parameter int unsigned ALPHABET_SIZE = 27
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [mtf_codec_pkg::CODE_W-1:0] code_in_i,
  input  wire logic                             restart_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [mtf_codec_pkg::CODE_W-1:0]      code_out_o,
  output logic                                  bad_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_data_i
);

  localparam int unsigned CW = mtf_codec_pkg::CODE_W;

  logic                       mode_q, mode_d;
  logic                       take_ok;
  logic                       in_accept;
  mtf_codec_pkg::cell_ctrl_t  ctrl;
  mtf_codec_pkg::result_t     result_d, result_q;
  logic [ALPHABET_SIZE:0]     hit_seen;
  logic [ALPHABET_SIZE-1:0]   first;
  logic [CW-1:0]              cur [ALPHABET_SIZE];
  logic [CW-1:0]              left [ALPHABET_SIZE];
  logic [CW-1:0]              front_sym;
  logic [CW-1:0]              hit_pos;
  logic [CW-1:0]              head_q;
  logic                       found;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mtf_codec_pkg::MODE_ENCODE;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Input handshake
  assign in_stall_o = !take_ok;
  assign in_accept  = in_valid_i && take_ok;

  assign ctrl.load    = in_accept;
  assign ctrl.restart = restart_i;
  assign ctrl.decode  = (mode_q == mtf_codec_pkg::MODE_DECODE);
  assign ctrl.code    = code_in_i;

  // Row of cells, front at index 0
  assign hit_seen[0] = 1'b0;
  assign found       = hit_seen[ALPHABET_SIZE];

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i] = front_sym;
    end else begin : g_body
      assign left[i] = cur[i-1];
    end

    mtf_codec_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .found_i    (found),
      .left_sym_i (left[i]),
      .before_i   (hit_seen[i]),
      .cur_o      (cur[i]),
      .before_o   (hit_seen[i+1]),
      .first_o    (first[i])
    );
  end

  // Collect hit symbol and hit position from the one-hot first-hit vector
  always_comb begin
    front_sym = '0;
    hit_pos   = '0;
    for (int unsigned i = 0; i < ALPHABET_SIZE; i++) begin
      if (first[i]) begin
        front_sym = front_sym | cur[i];
        hit_pos   = hit_pos | CW'(i);
      end
    end
  end

  // Form the result beat
  always_comb begin
    result_d.bad  = !found;
    result_d.code = '0;
    if (found) begin
      result_d.code = ctrl.decode ? front_sym : hit_pos;
    end
  end

  mtf_codec_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_accept),
    .result_i  (result_d),
    .stall_i   (out_stall_i),
    .take_ok_o (take_ok),
    .valid_o   (out_valid_o),
    .result_o  (result_q)
  );

  assign code_out_o = result_q.code;
  assign bad_item_o = result_q.bad;

  // Track the symbol moved to the front, for checking only
  always_ff @(posedge clk_i) begin
    if (in_accept && found) begin
      head_q <= front_sym;
    end
  end

  `MTFC_ASSERT(a_first_onehot0, $onehot0(first), "more than one first hit")
  `MTFC_ASSERT(a_found_first, found == (first != '0), "hit flag disagrees with first hit")
  `MTFC_ASSERT(a_bad_result, in_accept && !found |=> out_valid_o && bad_item_o && code_out_o == '0, "miss not flagged")
  `MTFC_ASSERT(a_head_moved, in_accept && found && !restart_i ##1 !restart_i |-> cur[0] == head_q, "hit symbol not at front")

endmodule

`default_nettype wire
